/* rtl/lsq_pkg.sv */
package lsq_pkg;

    localparam int WORD_W  = 32;
    localparam int WORD_SH = $clog2(WORD_W);

    localparam logic [1:0] ACT_INIT   = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_SINGLE = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] point_x;
        logic [7:0] point_y;
    } t_in;

    typedef struct packed {
        logic [7:0] head_x;
        logic [7:0] head_y;
        logic [7:0] tail_x;
        logic [7:0] tail_y;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
    } t_point;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_REM_LINK,
        S_REM_PT
    } t_state;

endpackage

/* rtl/lsq_ram.sv */
module lsq_ram #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                    i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                    o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/linked_segment_queue.sv */
// Channel   Handshake            Payload          Direction
// command   start / busy         i_in  (t_in)     in
// result    o_strobe (1 cycle)   o_out (t_out)    out
//
// Init, a rejected operation and the unused action code finish without raising busy; add
// runs a free-word pick from the full flags, then a used-bitmap read and lowest free bit;
// remove runs a link read, then a point read of the new tail.
// The result strobe rises in the cycle after the last busy cycle; a new command may be
// taken in that same cycle. Reset acts as an init with point (0,0) and is synchronous.
// The receiver cannot stall: every result beat is shown for exactly one cycle.
module linked_segment_queue #(
    parameter int SLOTS = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lsq_pkg::t_in  i_in,
    output logic          o_strobe,
    output lsq_pkg::t_out o_out
);
    import lsq_pkg::*;

    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORDS = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    t_point            r_head_pt, n_head_pt;
    t_point            r_tail_pt, n_tail_pt;
    t_point            r_pt, n_pt;
    logic [WAW-1:0]    r_w, n_w;
    logic [WORDS-1:0]  r_word_valid, n_word_valid;
    logic [WORDS-1:0]  r_word_full, n_word_full;
    logic              r_strobe, n_strobe;
    t_out              r_out, n_out;

    logic              bm_we;
    logic [WAW-1:0]    bm_waddr, bm_raddr;
    logic [WORD_W-1:0] bm_wdata, bm_rdata;
    logic              ln_we;
    logic [AW-1:0]     ln_waddr, ln_raddr, ln_rdata;
    logic              pt_we;
    logic [AW-1:0]     pt_waddr, pt_raddr;
    t_point            pt_wdata, pt_rdata;

    logic              free_found;
    logic [WAW-1:0]    free_w;
    logic [WORD_W-1:0] eff_word, masked_word, new_word;
    logic [WORD_SH-1:0] free_b, tail_b;
    logic [AW-1:0]     free_pos;

    function automatic logic [WORD_W-1:0] oor_mask(input logic [WAW-1:0] w);
        logic [WORD_W-1:0] m;
        for (int i = 0; i < WORD_W; i++) begin
            m[i] = ((int'(w) * WORD_W + i) >= SLOTS);
        end
        return m;
    endfunction

    lsq_ram #(.W(WORD_W), .D(WORDS)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    lsq_ram #(.W(AW), .D(SLOTS)) u_link (
        .i_clk   (i_clk),
        .i_we    (ln_we),
        .i_waddr (ln_waddr),
        .i_wdata (free_pos),
        .i_raddr (ln_raddr),
        .o_rdata (ln_rdata)
    );

    lsq_ram #(.W($bits(t_point)), .D(SLOTS)) u_point (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    always_comb begin
        free_found = 1'b0;
        free_w     = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (!r_word_full[i]) begin
                free_found = 1'b1;
                free_w     = WAW'(i);
            end
        end
    end

    always_comb begin
        if (r_word_valid[r_w]) begin
            eff_word = bm_rdata;
        end else begin
            eff_word = (r_w == '0) ? WORD_W'(1) : '0;
        end
        masked_word = eff_word | oor_mask(r_w);
        free_b = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!masked_word[i]) begin
                free_b = WORD_SH'(i);
            end
        end
        free_pos = AW'({r_w, free_b});
        tail_b   = WORD_SH'(r_tail);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_head_pt    <= '0;
            r_tail_pt    <= '0;
            r_word_valid <= '0;
            r_word_full  <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_head_pt    <= n_head_pt;
            r_tail_pt    <= n_tail_pt;
            r_word_valid <= n_word_valid;
            r_word_full  <= n_word_full;
            r_strobe     <= n_strobe;
        end
        r_pt  <= n_pt;
        r_w   <= n_w;
        r_out <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_head_pt    = r_head_pt;
        n_tail_pt    = r_tail_pt;
        n_pt         = r_pt;
        n_w          = r_w;
        n_word_valid = r_word_valid;
        n_word_full  = r_word_full;
        n_strobe     = 1'b0;
        n_out        = r_out;
        bm_we        = 1'b0;
        bm_waddr     = r_w;
        bm_raddr     = r_w;
        new_word     = eff_word;
        bm_wdata     = new_word;
        ln_we        = 1'b0;
        ln_waddr     = r_head;
        ln_raddr     = r_tail;
        pt_we        = 1'b0;
        pt_waddr     = free_pos;
        pt_raddr     = ln_rdata;
        pt_wdata     = r_pt;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pt = '{x: i_in.point_x, y: i_in.point_y};
                    unique case (i_in.action)
                        ACT_INIT: begin
                            n_word_valid = '0;
                            n_word_full  = '0;
                            n_head       = '0;
                            n_tail       = '0;
                            n_head_pt    = n_pt;
                            n_tail_pt    = n_pt;
                            pt_we        = 1'b1;
                            pt_waddr     = '0;
                            pt_wdata     = n_pt;
                            n_strobe     = 1'b1;
                            n_out        = {n_head_pt, n_tail_pt, ST_DONE};
                        end
                        ACT_ADD: begin
                            if (free_found) begin
                                n_w      = free_w;
                                bm_raddr = free_w;
                                n_state  = S_ADD;
                            end else begin
                                n_strobe = 1'b1;
                                n_out    = {r_head_pt, r_tail_pt, ST_FULL};
                            end
                        end
                        ACT_REMOVE: begin
                            if (r_tail == r_head) begin
                                n_strobe = 1'b1;
                                n_out    = {r_head_pt, r_tail_pt, ST_SINGLE};
                            end else begin
                                n_w      = WAW'(r_tail >> WORD_SH);
                                bm_raddr = n_w;
                                n_state  = S_REM_LINK;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_out    = {r_head_pt, r_tail_pt, ST_DONE};
                        end
                    endcase
                end
            end
            S_ADD: begin
                new_word            = eff_word | (WORD_W'(1) << free_b);
                bm_wdata            = new_word;
                bm_we               = 1'b1;
                n_word_valid[r_w]   = 1'b1;
                n_word_full[r_w]    = &(new_word | oor_mask(r_w));
                ln_we               = 1'b1;
                pt_we               = 1'b1;
                n_head              = free_pos;
                n_head_pt           = r_pt;
                n_strobe            = 1'b1;
                n_out               = {r_pt, r_tail_pt, ST_DONE};
                n_state             = S_IDLE;
            end
            S_REM_LINK: begin
                new_word            = eff_word & ~(WORD_W'(1) << tail_b);
                bm_wdata            = new_word;
                bm_we               = 1'b1;
                n_word_valid[r_w]   = 1'b1;
                n_word_full[r_w]    = 1'b0;
                n_tail              = ln_rdata;
                n_state             = S_REM_PT;
            end
            S_REM_PT: begin
                n_tail_pt = pt_rdata;
                n_strobe  = 1'b1;
                n_out     = {r_head_pt, pt_rdata, ST_DONE};
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_head) < SLOTS && int'(r_tail) < SLOTS)
        else $error("head or tail slot out of range");

    a_add_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADD |-> $past(start && !busy && i_in.action == ACT_ADD))
        else $error("add step without an add beat");

    a_rem_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REM_LINK |=> r_state == S_REM_PT)
        else $error("remove sequence broken");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_out.status == ST_SINGLE |-> r_head == r_tail)
        else $error("single-point status with distinct head and tail");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_state == S_IDLE)
        else $error("result beat while sequence still running");
endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import lsq_pkg::*;

    localparam int SLOTS = 128;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int RANDOM_ITEMS = 1450;
    localparam int MAX_GAP = 18;
    localparam logic [1:0] ACT_NOP = 2'd3;

    typedef struct {
        t_in         cmd;
        int unsigned gap;
    } t_cmd_beat;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_in;
    logic o_strobe;
    t_out o_out;

    linked_segment_queue #(
        .SLOTS(SLOTS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_strobe(o_strobe),
        .o_out   (o_out)
    );

    t_cmd_beat pending_cmds[$];
    t_out      expected_views[$];

    logic              slot_taken[SLOTS];
    logic [IDX_W-1:0]  slot_next[SLOTS];
    t_point            slot_pt[SLOTS];
    logic [IDX_W-1:0]  head_idx;
    logic [IDX_W-1:0]  tail_idx;

    int unsigned total_cmds;
    int unsigned accepted_cnt;
    int unsigned issued_cnt;
    int unsigned result_cnt;
    int unsigned full_cnt;
    int unsigned single_cnt;
    int unsigned error_cnt;
    int unsigned gap_left;
    bit          driving;
    bit          quiet;
    int          occupancy;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out queue_step(t_in c);
        t_out r;
        int   free_idx;
        r = '0;
        r.status = ST_DONE;
        case (c.action)
            ACT_INIT: begin
                for (int i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
                slot_taken[0] = 1'b1;
                slot_pt[0] = '{x: c.point_x, y: c.point_y};
                head_idx = '0;
                tail_idx = '0;
            end
            ACT_ADD: begin
                free_idx = -1;
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!slot_taken[i]) free_idx = i;
                end
                if (free_idx < 0) begin
                    r.status = ST_FULL;
                end else begin
                    slot_taken[free_idx] = 1'b1;
                    slot_pt[free_idx] = '{x: c.point_x, y: c.point_y};
                    slot_next[head_idx] = IDX_W'(free_idx);
                    head_idx = IDX_W'(free_idx);
                end
            end
            ACT_REMOVE: begin
                if (tail_idx == head_idx) begin
                    r.status = ST_SINGLE;
                end else begin
                    slot_taken[tail_idx] = 1'b0;
                    tail_idx = slot_next[tail_idx];
                end
            end
            default: ;
        endcase
        r.head_x = slot_pt[head_idx].x;
        r.head_y = slot_pt[head_idx].y;
        r.tail_x = slot_pt[tail_idx].x;
        r.tail_y = slot_pt[tail_idx].y;
        return r;
    endfunction

    task automatic flag_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_cnt++;
        end
    endtask

    // Occupancy tracked here only steers the phases of the random stream.
    task automatic queue_cmd(logic [1:0] action, logic [7:0] x, logic [7:0] y);
        t_cmd_beat b;
        b.cmd.action  = action;
        b.cmd.point_x = x;
        b.cmd.point_y = y;
        b.gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        pending_cmds.push_back(b);
        total_cmds++;
        case (action)
            ACT_INIT: occupancy = 1;
            ACT_ADD: if (occupancy < SLOTS) occupancy++;
            ACT_REMOVE: if (occupancy > 1) occupancy--;
            default: ;
        endcase
    endtask

    task automatic queue_random_point(logic [1:0] action);
        queue_cmd(action, 8'($urandom), 8'($urandom));
    endtask

    task automatic queue_mixed(int n, bit any_action);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (any_action) queue_random_point(2'($urandom));
            else if (r < 5) queue_random_point(ACT_INIT);
            else if (r < 50) queue_random_point(ACT_ADD);
            else if (r < 92) queue_random_point(ACT_REMOVE);
            else queue_random_point(ACT_NOP);
        end
    endtask

    task automatic queue_fill();
        int r;
        while (occupancy < SLOTS) begin
            r = $urandom_range(0, 99);
            if (r < 88) queue_random_point(ACT_ADD);
            else if (r < 97) queue_random_point(ACT_REMOVE);
            else queue_random_point(ACT_NOP);
        end
        repeat ($urandom_range(1, 3)) queue_random_point(ACT_ADD);
    endtask

    task automatic queue_drain();
        int r;
        while (occupancy > 1) begin
            r = $urandom_range(0, 99);
            if (r < 85) queue_random_point(ACT_REMOVE);
            else if (r < 97) queue_random_point(ACT_ADD);
            else queue_random_point(ACT_NOP);
        end
        repeat ($urandom_range(1, 3)) queue_random_point(ACT_REMOVE);
    endtask

    // Driver: present one beat per item after its gap, keep start high across back-to-back beats.
    always @(negedge i_clk) begin
        if (driving) begin
            if (accepted_cnt == issued_cnt && pending_cmds.size() > 0) begin
                gap_left = pending_cmds[0].gap;
                issued_cnt++;
            end
            if (accepted_cnt < issued_cnt && gap_left == 0) begin
                start <= 1'b1;
                i_in  <= pending_cmds[0].cmd;
            end else begin
                start <= 1'b0;
                if (accepted_cnt < issued_cnt) gap_left--;
            end
        end
    end

    // Monitor: check the result beat first, then record the command taken at this edge.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_strobe) begin
                result_cnt++;
                if (expected_views.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, o_out);
                    error_cnt++;
                end else begin
                    want = expected_views.pop_front();
                    flag_field("head_x", want.head_x, o_out.head_x);
                    flag_field("head_y", want.head_y, o_out.head_y);
                    flag_field("tail_x", want.tail_x, o_out.tail_x);
                    flag_field("tail_y", want.tail_y, o_out.tail_y);
                    flag_field("status", 8'(want.status), 8'(o_out.status));
                end
            end
            if (start && !busy) begin
                want = queue_step(i_in);
                if (want.status == ST_FULL) full_cnt++;
                if (want.status == ST_SINGLE) single_cnt++;
                expected_views.push_back(want);
                void'(pending_cmds.pop_front());
                accepted_cnt++;
            end
        end
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int phase;
        start = 1'b0;
        i_in = '0;
        i_rst_n = 1'b0;
        driving = 1'b0;
        quiet = 1'b0;
        gap_left = 0;
        total_cmds = 0;
        accepted_cnt = 0;
        issued_cnt = 0;
        result_cnt = 0;
        full_cnt = 0;
        single_cnt = 0;
        error_cnt = 0;
        occupancy = 1;
        for (int i = 0; i < SLOTS; i++) begin
            slot_taken[i] = 1'b0;
            slot_next[i] = '0;
            slot_pt[i] = '0;
        end
        slot_taken[0] = 1'b1;
        head_idx = '0;
        tail_idx = '0;

        queue_cmd(ACT_NOP, 8'hFF, 8'hFF);
        queue_cmd(ACT_REMOVE, 8'h00, 8'h00);
        queue_cmd(ACT_ADD, 8'hFF, 8'h00);
        queue_cmd(ACT_ADD, 8'h00, 8'hFF);
        queue_cmd(ACT_NOP, 8'h00, 8'h00);
        queue_cmd(ACT_REMOVE, 8'hFF, 8'hFF);
        queue_cmd(ACT_REMOVE, 8'h00, 8'h00);
        queue_cmd(ACT_REMOVE, 8'h00, 8'h00);
        queue_cmd(ACT_INIT, 8'hFF, 8'hFF);
        queue_cmd(ACT_ADD, 8'hAA, 8'h55);
        queue_cmd(ACT_ADD, 8'h55, 8'hAA);
        queue_cmd(ACT_REMOVE, 8'h00, 8'h00);
        queue_cmd(ACT_ADD, 8'h01, 8'h80);
        queue_cmd(ACT_INIT, 8'h00, 8'h00);
        queue_cmd(ACT_ADD, 8'hFF, 8'hFF);
        queue_cmd(ACT_NOP, 8'h5A, 8'hA5);
        queue_cmd(ACT_REMOVE, 8'h00, 8'h00);
        queue_cmd(ACT_REMOVE, 8'h00, 8'h00);
        queue_cmd(ACT_INIT, 8'h80, 8'h01);
        queue_cmd(ACT_REMOVE, 8'h00, 8'h00);

        queue_fill();
        queue_drain();
        while (total_cmds < RANDOM_ITEMS + 20) begin
            quiet = ($urandom_range(0, 3) == 0);
            phase = $urandom_range(0, 5);
            case (phase)
                0: queue_fill();
                1: queue_drain();
                2, 3: queue_mixed($urandom_range(30, 60), 1'b0);
                4: queue_mixed($urandom_range(5, 15), 1'b1);
                default: begin
                    queue_fill();
                    queue_mixed($urandom_range(20, 40), 1'b0);
                end
            endcase
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        driving = 1'b1;

        while (accepted_cnt < total_cmds || expected_views.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d commands, checked %0d results (%0d full-table, %0d last-point rejects)",
                 total_cmds, result_cnt, full_cnt, single_cnt);
        if (error_cnt == 0 && expected_views.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
